// File: sv/qmr_pkg.sv
`timescale 1ns / 1ps

package qmr_pkg;

    // component format and internal arithmetic widths
    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 14;
    localparam int OP_W       = COMP_WIDTH + 1;
    localparam int PROD_W     = 2 * OP_W;
    localparam int SUM_W      = PROD_W + 2;

    // component positions
    localparam int IX = 0;
    localparam int IY = 1;
    localparam int IZ = 2;
    localparam int IW = 3;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [OP_W-1:0]       op_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    typedef comp_t comp4_t [4];
    typedef op_t   op4_t   [4];
    typedef sum_t  sum4_t  [4];

    typedef struct packed {
        logic                  sat;
        logic [COMP_WIDTH-1:0] val;
    } rnd_t;

    localparam sum_t SAT_HI = sum_t'((longint'(1) <<< (COMP_WIDTH - 1)) - 1);
    localparam sum_t SAT_LO = -SAT_HI - sum_t'(1);
    localparam sum_t HALF   = sum_t'(longint'(1) <<< (FRAC_BITS - 1));

    // round half up to the component format, then clip
    function automatic rnd_t round_sat(input sum_t s);
        sum_t q;
        rnd_t r;
        q = (s + HALF) >>> FRAC_BITS;
        if (q > SAT_HI)
        begin
            r = {1'b1, SAT_HI[COMP_WIDTH-1:0]};
        end
        else if (q < SAT_LO)
        begin
            r = {1'b1, SAT_LO[COMP_WIDTH-1:0]};
        end
        else
        begin
            r = {1'b0, q[COMP_WIDTH-1:0]};
        end
        return r;
    endfunction

endpackage

// File: sv/qmr_hamilton.sv
`timescale 1ns / 1ps

module qmr_hamilton (
    input  logic            clk,
    input  logic            en,
    input  qmr_pkg::op4_t   p,
    input  qmr_pkg::op4_t   q,
    output qmr_pkg::sum4_t  sum
);

    qmr_pkg::prod_t prod_reg [4][4];

    // all sixteen partial products, registered at full width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[i][j] <= qmr_pkg::prod_t'(p[i]) * qmr_pkg::prod_t'(q[j]);
                end
            end
        end
    end

    // signed combination per hamilton product component
    always_comb
    begin
        sum[qmr_pkg::IX] = qmr_pkg::sum_t'(prod_reg[3][0]) + qmr_pkg::sum_t'(prod_reg[0][3])
                         + qmr_pkg::sum_t'(prod_reg[1][2]) - qmr_pkg::sum_t'(prod_reg[2][1]);
        sum[qmr_pkg::IY] = qmr_pkg::sum_t'(prod_reg[3][1]) - qmr_pkg::sum_t'(prod_reg[0][2])
                         + qmr_pkg::sum_t'(prod_reg[1][3]) + qmr_pkg::sum_t'(prod_reg[2][0]);
        sum[qmr_pkg::IZ] = qmr_pkg::sum_t'(prod_reg[3][2]) + qmr_pkg::sum_t'(prod_reg[0][1])
                         - qmr_pkg::sum_t'(prod_reg[1][0]) + qmr_pkg::sum_t'(prod_reg[2][3]);
        sum[qmr_pkg::IW] = qmr_pkg::sum_t'(prod_reg[3][3]) - qmr_pkg::sum_t'(prod_reg[0][0])
                         - qmr_pkg::sum_t'(prod_reg[1][1]) - qmr_pkg::sum_t'(prod_reg[2][2]);
    end

endmodule

// File: sv/quaternion_multiply_rotate_core.sv
`timescale 1ns / 1ps
// path: an accepted request passes through the input register, the products, the rounded
// intermediate, the second products and the output register, in that order
// throughput: one request per cycle; a stalled output holds only the full stages
// behind it, empty stages keep filling
// reset: asynchronous, active low; clears all stage valid bits, payload is not reset

module quaternion_multiply_rotate_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  qmr_pkg::comp_t       a_x,
    input  qmr_pkg::comp_t       a_y,
    input  qmr_pkg::comp_t       a_z,
    input  qmr_pkg::comp_t       a_w,
    input  qmr_pkg::comp_t       b_x,
    input  qmr_pkg::comp_t       b_y,
    input  qmr_pkg::comp_t       b_z,
    input  qmr_pkg::comp_t       b_w,
    output logic                 out_valid,
    input  logic                 out_stall,
    output qmr_pkg::comp_t       res_x,
    output qmr_pkg::comp_t       res_y,
    output qmr_pkg::comp_t       res_z,
    output qmr_pkg::comp_t       res_w,
    output logic                 saturated
);

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    logic            mode0_reg, mode1_reg, mode2_reg, mode3_reg;
    qmr_pkg::comp4_t a0_reg, b0_reg, a1_reg, a2_reg;
    qmr_pkg::comp4_t p2_reg, p3_reg, res_reg;
    logic            sat2_reg, sat3_reg, sat4_reg;

    qmr_pkg::op4_t   h1_p, h1_q, h2_p, h2_q;
    qmr_pkg::sum4_t  h1_sum, h2_sum;
    qmr_pkg::rnd_t   h1_rnd [4];
    qmr_pkg::rnd_t   h2_rnd [4];
    qmr_pkg::comp4_t p2_next, res_next;
    logic            sat2_next, sat4_next;

    // stage may load when empty or when the next stage moves on
    assign rdy4     = !v4_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_stall = !rdy0;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= in_valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            mode0_reg          <= mode;
            a0_reg[qmr_pkg::IX] <= a_x;
            a0_reg[qmr_pkg::IY] <= a_y;
            a0_reg[qmr_pkg::IZ] <= a_z;
            a0_reg[qmr_pkg::IW] <= a_w;
            b0_reg[qmr_pkg::IX] <= b_x;
            b0_reg[qmr_pkg::IY] <= b_y;
            b0_reg[qmr_pkg::IZ] <= b_z;
            b0_reg[qmr_pkg::IW] <= b_w;
        end
    end

    // first product a*b, vector w forced to zero when rotating
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            h1_p[i] = qmr_pkg::op_t'(a0_reg[i]);
            h1_q[i] = qmr_pkg::op_t'(b0_reg[i]);
        end
        if (mode0_reg)
        begin
            h1_q[qmr_pkg::IW] = '0;
        end
    end

    qmr_hamilton u_h1 (
        .clk (clk),
        .en  (rdy1),
        .p   (h1_p),
        .q   (h1_q),
        .sum (h1_sum)
    );

    // side data alongside the first products
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            mode1_reg <= mode0_reg;
            a1_reg    <= a0_reg;
        end
    end

    // round and clip the first product
    always_comb
    begin
        sat2_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            h1_rnd[i]  = qmr_pkg::round_sat(h1_sum[i]);
            p2_next[i] = h1_rnd[i].val;
            sat2_next  = sat2_next | h1_rnd[i].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            mode2_reg <= mode1_reg;
            a2_reg    <= a1_reg;
            p2_reg    <= p2_next;
            sat2_reg  <= sat2_next;
        end
    end

    // second product p*conj(a), negation one bit wider so it is exact
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            h2_p[i] = qmr_pkg::op_t'(p2_reg[i]);
            h2_q[i] = -qmr_pkg::op_t'(a2_reg[i]);
        end
        h2_q[qmr_pkg::IW] = qmr_pkg::op_t'(a2_reg[qmr_pkg::IW]);
    end

    qmr_hamilton u_h2 (
        .clk (clk),
        .en  (rdy3),
        .p   (h2_p),
        .q   (h2_q),
        .sum (h2_sum)
    );

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            mode3_reg <= mode2_reg;
            p3_reg    <= p2_reg;
            sat3_reg  <= sat2_reg;
        end
    end

    // result select: product passes through, rotation takes x,y,z of the second product
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            h2_rnd[i] = qmr_pkg::round_sat(h2_sum[i]);
        end
        if (mode3_reg)
        begin
            res_next[qmr_pkg::IX] = h2_rnd[qmr_pkg::IX].val;
            res_next[qmr_pkg::IY] = h2_rnd[qmr_pkg::IY].val;
            res_next[qmr_pkg::IZ] = h2_rnd[qmr_pkg::IZ].val;
            res_next[qmr_pkg::IW] = '0;
            sat4_next = sat3_reg | h2_rnd[qmr_pkg::IX].sat | h2_rnd[qmr_pkg::IY].sat
                      | h2_rnd[qmr_pkg::IZ].sat;
        end
        else
        begin
            res_next  = p3_reg;
            sat4_next = sat3_reg;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            res_reg  <= res_next;
            sat4_reg <= sat4_next;
        end
    end

    assign out_valid = v4_reg;
    assign res_x     = res_reg[qmr_pkg::IX];
    assign res_y     = res_reg[qmr_pkg::IY];
    assign res_z     = res_reg[qmr_pkg::IZ];
    assign res_w     = res_reg[qmr_pkg::IW];
    assign saturated = sat4_reg;

endmodule

// File: sv/qmr_checker.sv
`timescale 1ns / 1ps

module qmr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input qmr_pkg::comp_t res_x,
    input qmr_pkg::comp_t res_y,
    input qmr_pkg::comp_t res_z,
    input qmr_pkg::comp_t res_w,
    input logic           saturated
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(res_x) && $stable(res_y) && $stable(res_z)
            && $stable(res_w) && $stable(saturated))
        else $error("result changed while stalled");

    // the input only backs up when the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the output free");

    // an output stall held for a while fills the pipe and stops the input
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && $past(out_valid && out_stall, 1)
            && $past(out_valid && out_stall, 2) && $past(out_valid && out_stall, 3)
            && $past(out_valid && out_stall, 4) && $past(in_valid, 1) && $past(in_valid, 2)
            && $past(in_valid, 3) && $past(in_valid, 4) && $past(in_valid, 5)
            |-> in_stall)
        else $error("request taken beyond pipeline depth");

endmodule

bind quaternion_multiply_rotate_core qmr_checker u_qmr_checker (.*);

// File: tb/sv/quat_result_monitor.sv
`timescale 1ns / 1ps

package quat_tb_pkg;

    // operation selected by the mode bit of a request
    typedef enum logic {
        MODE_PRODUCT = 1'b0,
        MODE_ROTATE  = 1'b1
    } quat_mode_e;

endpackage

module quat_result_monitor (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  logic           mode,
    input  qmr_pkg::comp_t a_x,
    input  qmr_pkg::comp_t a_y,
    input  qmr_pkg::comp_t a_z,
    input  qmr_pkg::comp_t a_w,
    input  qmr_pkg::comp_t b_x,
    input  qmr_pkg::comp_t b_y,
    input  qmr_pkg::comp_t b_z,
    input  qmr_pkg::comp_t b_w,
    input  logic           out_valid,
    input  logic           out_stall,
    input  qmr_pkg::comp_t res_x,
    input  qmr_pkg::comp_t res_y,
    input  qmr_pkg::comp_t res_z,
    input  qmr_pkg::comp_t res_w,
    input  logic           saturated,
    output int             fail_count,
    output int             results_waiting
);

    import qmr_pkg::*;
    import quat_tb_pkg::*;

    // exact integer components, wide enough for any sum of four products
    typedef struct packed {
        longint x;
        longint y;
        longint z;
        longint w;
    } quat_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
        comp_t w;
        logic  clipped;
    } quat_result_t;

    quat_result_t results_due[$];

    initial
    begin
        fail_count      = 0;
        results_waiting = 0;
    end

    // round half up to the component format and clip to its range
    function automatic longint round_clip(input longint acc, inout bit clipped);
        longint q;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
        lo = -hi - 1;
        q  = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (q > hi)
        begin
            clipped = 1'b1;
            q = hi;
        end
        else if (q < lo)
        begin
            clipped = 1'b1;
            q = lo;
        end
        return q;
    endfunction

    // hamilton product p*q, w left at zero when not wanted
    function automatic quat_t hamilton(input quat_t p, input quat_t q, input bit want_w,
                                       inout bit clipped);
        quat_t r;
        r.x = round_clip(p.w * q.x + p.x * q.w + p.y * q.z - p.z * q.y, clipped);
        r.y = round_clip(p.w * q.y - p.x * q.z + p.y * q.w + p.z * q.x, clipped);
        r.z = round_clip(p.w * q.z + p.x * q.y - p.y * q.x + p.z * q.w, clipped);
        r.w = 0;
        if (want_w)
        begin
            r.w = round_clip(p.w * q.w - p.x * q.x - p.y * q.y - p.z * q.z, clipped);
        end
        return r;
    endfunction

    // product a*b, or rotation of b's vector part by a via a*v*conj(a)
    function automatic quat_result_t quat_mul_rotate(input logic op, input quat_t a,
                                                     input quat_t b);
        quat_result_t res;
        quat_t        p;
        quat_t        c;
        quat_t        r;
        bit           clipped;
        clipped = 1'b0;
        if (op == MODE_PRODUCT)
        begin
            r = hamilton(a, b, 1'b1, clipped);
        end
        else
        begin
            b.w = 0;
            p   = hamilton(a, b, 1'b1, clipped);
            c.x = -a.x;
            c.y = -a.y;
            c.z = -a.z;
            c.w = a.w;
            r   = hamilton(p, c, 1'b0, clipped);
        end
        res.x       = comp_t'(r.x);
        res.y       = comp_t'(r.y);
        res.z       = comp_t'(r.z);
        res.w       = comp_t'(r.w);
        res.clipped = clipped;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    // capture accepted requests, check accepted results in order
    always @(posedge clk)
    begin : watch
        quat_result_t due;
        quat_t        a;
        quat_t        b;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                a.x = a_x;
                a.y = a_y;
                a.z = a_z;
                a.w = a_w;
                b.x = b_x;
                b.y = b_y;
                b.z = b_z;
                b.w = b_w;
                results_due.push_back(quat_mul_rotate(mode, a, b));
            end
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    report_mismatch("result with no request due", 0, 0);
                end
                else
                begin
                    due = results_due.pop_front();
                    if (res_x !== due.x)
                    begin
                        report_mismatch("res_x", res_x, due.x);
                    end
                    if (res_y !== due.y)
                    begin
                        report_mismatch("res_y", res_y, due.y);
                    end
                    if (res_z !== due.z)
                    begin
                        report_mismatch("res_z", res_z, due.z);
                    end
                    if (res_w !== due.w)
                    begin
                        report_mismatch("res_w", res_w, due.w);
                    end
                    if (saturated !== due.clipped)
                    begin
                        report_mismatch("saturated", saturated, due.clipped);
                    end
                end
            end
            results_waiting = results_due.size();
        end
    end

endmodule

// File: tb/sv/tb_quaternion_multiply_rotate_core.sv
`timescale 1ns / 1ps

module tb_quaternion_multiply_rotate_core;

    import qmr_pkg::*;
    import quat_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 10;
    localparam int BLOCKS       = 12;
    localparam int BLOCK_ITEMS  = 100;
    localparam comp_t ONE       = comp_t'(16384);
    localparam comp_t COS45     = comp_t'(11585);
    localparam comp_t MAXV      = comp_t'(32767);
    localparam comp_t MINV      = comp_t'(-32768);

    logic  clk;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_stall;
    logic  mode      = MODE_PRODUCT;
    comp_t a_x       = '0;
    comp_t a_y       = '0;
    comp_t a_z       = '0;
    comp_t a_w       = '0;
    comp_t b_x       = '0;
    comp_t b_y       = '0;
    comp_t b_z       = '0;
    comp_t b_w       = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    comp_t res_x;
    comp_t res_y;
    comp_t res_z;
    comp_t res_w;
    logic  saturated;

    int fail_count;
    int results_waiting;
    int cycle_count  = 0;
    bit sender_idles = 1'b1;
    bit sink_idles   = 1'b1;
    bit hold_off_req = 1'b0;

    quaternion_multiply_rotate_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .a_w       (a_w),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .b_w       (b_w),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_z     (res_z),
        .res_w     (res_w),
        .saturated (saturated)
    );

    quat_result_monitor result_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .a_x             (a_x),
        .a_y             (a_y),
        .a_z             (a_z),
        .a_w             (a_w),
        .b_x             (b_x),
        .b_y             (b_y),
        .b_z             (b_z),
        .b_w             (b_w),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .res_x           (res_x),
        .res_y           (res_y),
        .res_z           (res_z),
        .res_w           (res_w),
        .saturated       (saturated),
        .fail_count      (fail_count),
        .results_waiting (results_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // offer one request, valid stays high afterwards unless the next one idles first
    task automatic send_request(input quat_mode_e op, input comp_t ax, input comp_t ay,
                                input comp_t az, input comp_t aw, input comp_t bx,
                                input comp_t by, input comp_t bz, input comp_t bw);
        int gap;
        gap = sender_idles ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        a_x      <= ax;
        a_y      <= ay;
        a_z      <= az;
        a_w      <= aw;
        b_x      <= bx;
        b_y      <= by;
        b_z      <= bz;
        b_w      <= bw;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_waiting == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // full range, near-unit magnitudes or corner values
    function automatic comp_t rand_comp(input int style);
        comp_t corners [8];
        corners = '{MINV, MAXV, comp_t'(-1), comp_t'(0), comp_t'(1), ONE, -ONE, COS45};
        if (style < 4)
        begin
            return comp_t'($urandom);
        end
        else if (style < 8)
        begin
            return comp_t'(int'($urandom_range(0, 32768)) - 16384);
        end
        return corners[$urandom_range(0, 7)];
    endfunction

    task automatic send_random();
        int         style;
        quat_mode_e op;
        style = $urandom_range(0, 9);
        op    = quat_mode_e'($urandom_range(0, 1));
        send_request(op, rand_comp(style), rand_comp(style), rand_comp(style),
                     rand_comp(style), rand_comp(style), rand_comp(style),
                     rand_comp(style), rand_comp(style));
    endtask

    // result side: random stall per result, or one long hold-off on request
    initial
    begin : sink
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                n = HOLD_CYCLES;
            end
            else
            begin
                n = sink_idles ? $urandom_range(0, 5) : 0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
        end
    end

    // reset, directed requests, back-pressure, then random blocks
    initial
    begin : stimulus
        int blk;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zeros, identity, and clipping in both directions
        send_request(MODE_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(MODE_PRODUCT, 0, 0, 0, ONE, 1000, -2000, 3000, -4000);
        send_request(MODE_PRODUCT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
        send_request(MODE_PRODUCT, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
        send_request(MODE_PRODUCT, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV);
        // exact halves round up, including negative ones
        send_request(MODE_PRODUCT, 0, 0, 0, 1, 8192, -8192, 8193, 8191);
        send_request(MODE_PRODUCT, comp_t'(16'h5555), comp_t'(16'haaaa), comp_t'(16'h5555),
                     comp_t'(16'haaaa), comp_t'(16'haaaa), comp_t'(16'h5555),
                     comp_t'(16'haaaa), comp_t'(16'h5555));
        send_request(MODE_PRODUCT, 1, -1, 1, -1, MINV, MAXV, MINV, MAXV);
        // rotation: identity with b_w ignored, quarter turn about z, half turn about x
        send_request(MODE_ROTATE, 0, 0, 0, ONE, 5000, -6000, 7000, 12345);
        send_request(MODE_ROTATE, 0, 0, COS45, COS45, ONE, 0, 0, MINV);
        send_request(MODE_ROTATE, ONE, 0, 0, 0, MINV, MAXV, -1, -1);
        // conjugate of the most negative value, intermediate clipping
        send_request(MODE_ROTATE, MINV, MINV, MINV, MINV, ONE, ONE, ONE, 0);
        send_request(MODE_ROTATE, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
        send_request(MODE_ROTATE, MINV, 0, 0, 0, 0, ONE, 0, MAXV);
        send_request(MODE_ROTATE, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // long hold-off on results while requests keep coming
        hold_off_req = 1'b1;
        sender_idles = 1'b0;
        repeat (30) send_random();
        sender_idles = 1'b1;
        drain();

        for (blk = 0; blk < BLOCKS; blk++)
        begin
            sender_idles = (blk % 4 != 1);
            sink_idles   = (blk % 4 != 2);
            if (blk == 6)
            begin
                hold_off_req = 1'b1;
                sender_idles = 1'b0;
            end
            repeat (BLOCK_ITEMS) send_random();
            if (blk == 8)
            begin
                drain();
            end
        end
        drain();

        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
